FILE: rtl/core/bbc_pkg.sv
// Package with the shared constants and codes of the bracket balance checker.
`default_nettype none

package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int KIND_W      = 3;

	localparam logic [LVL_W-1:0] LEVEL_FULL = LVL_W'(STACK_DEPTH);

	localparam logic [KIND_W-1:0] KIND_PAREN = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BRACK = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BRACE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ANGLE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_STAR  = 3'd4;

	localparam logic [1:0] HOLD_NONE  = 2'd0;
	localparam logic [1:0] HOLD_PAREN = 2'd1;
	localparam logic [1:0] HOLD_STAR  = 2'd2;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

`default_nettype wire

FILE: rtl/core/bracket_balance_checker.sv
// Top level of the bracket balance checker with its stack control and result register.
`default_nettype none

// The block takes one byte word per cycle on the slave stream when not stalled, and
// gives one result word per line on the master stream when a word with tlast high closes the
// line. An open parenthesis followed by one of [ { < stalls the slave stream for the second
// push, because the stack memory takes one write a cycle and that pair pushes two entries.
// The top of the stack sits in a register and the entry below it is read ahead of use from
// the stack memory, whose read port is registered. An end-of-line word also waits while the
// previous result is still held on the master side; byte words pass while a result waits.
module bracket_balance_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // text_byte
	input  wire logic       s_axis_tlast,   // line_end
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata    // balanced, overflowed, zero fill
);

	localparam int LVL_W  = bbc_pkg::LVL_W;
	localparam int ADDR_W = bbc_pkg::ADDR_W;
	localparam int KIND_W = bbc_pkg::KIND_W;

	logic [LVL_W-1:0]  level_q;
	logic [KIND_W-1:0] top_q;
	logic [1:0]        hold_q;
	logic              failed_q;
	logic              overflow_q;
	logic              extra_q;
	logic [KIND_W-1:0] extra_kind_q;
	logic              fwd_q;
	logic [KIND_W-1:0] fwd_data_q;
	logic              out_valid_q;
	logic              out_bal_q;
	logic              out_ovf_q;

	logic              in_acc;
	logic              eol_acc;
	logic              byte_go;
	logic              full;
	logic [KIND_W-1:0] below;
	logic [KIND_W-1:0] rd_data;

	logic              is_open;
	logic [KIND_W-1:0] open_kind;
	logic              is_close;
	logic [KIND_W-1:0] close_kind;

	logic              p_push;
	logic              p_pop;
	logic [KIND_W-1:0] p_kind;
	logic [1:0]        p_hold;

	logic              op_push;
	logic              op_pop;
	logic [KIND_W-1:0] op_kind;
	logic              force_fail;
	logic [1:0]        nxt_hold;
	logic              set_extra;
	logic [KIND_W-1:0] set_extra_kind;

	logic              push_ok;
	logic              pop_ok;
	logic              push_ovf;
	logic              do_fail;
	logic [LVL_W-1:0]  next_level;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;

	logic              final_push;
	logic              res_bal;
	logic              res_ovf;

	assign s_axis_tready = !extra_q && (!s_axis_tlast || !out_valid_q || m_axis_tready);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign eol_acc = in_acc && s_axis_tlast;
	assign byte_go = in_acc && !s_axis_tlast && !failed_q;
	assign full    = (level_q == bbc_pkg::LEVEL_FULL);
	assign below   = fwd_q ? fwd_data_q : rd_data;

	always_comb begin
		is_open    = 1'b0;
		open_kind  = bbc_pkg::KIND_PAREN;
		is_close   = 1'b0;
		close_kind = bbc_pkg::KIND_PAREN;
		unique case (s_axis_tdata)
			bbc_pkg::CH_LBRACK: begin
				is_open   = 1'b1;
				open_kind = bbc_pkg::KIND_BRACK;
			end
			bbc_pkg::CH_LBRACE: begin
				is_open   = 1'b1;
				open_kind = bbc_pkg::KIND_BRACE;
			end
			bbc_pkg::CH_LT: begin
				is_open   = 1'b1;
				open_kind = bbc_pkg::KIND_ANGLE;
			end
			bbc_pkg::CH_RPAREN: begin
				is_close   = 1'b1;
				close_kind = bbc_pkg::KIND_PAREN;
			end
			bbc_pkg::CH_RBRACK: begin
				is_close   = 1'b1;
				close_kind = bbc_pkg::KIND_BRACK;
			end
			bbc_pkg::CH_RBRACE: begin
				is_close   = 1'b1;
				close_kind = bbc_pkg::KIND_BRACE;
			end
			bbc_pkg::CH_GT: begin
				is_close   = 1'b1;
				close_kind = bbc_pkg::KIND_ANGLE;
			end
			default: begin
			end
		endcase
	end

	// Handling of a byte with nothing held, also used after a held star not followed by ')'.
	always_comb begin
		p_push = 1'b0;
		p_pop  = 1'b0;
		p_kind = open_kind;
		p_hold = bbc_pkg::HOLD_NONE;
		if (s_axis_tdata == bbc_pkg::CH_LPAREN) begin
			p_hold = bbc_pkg::HOLD_PAREN;
		end else if (s_axis_tdata == bbc_pkg::CH_STAR) begin
			p_hold = bbc_pkg::HOLD_STAR;
		end else if (is_open) begin
			p_push = 1'b1;
		end else if (is_close) begin
			p_pop  = 1'b1;
			p_kind = close_kind;
		end
	end

	always_comb begin
		op_push        = 1'b0;
		op_pop         = 1'b0;
		op_kind        = bbc_pkg::KIND_PAREN;
		force_fail     = 1'b0;
		nxt_hold       = bbc_pkg::HOLD_NONE;
		set_extra      = 1'b0;
		set_extra_kind = open_kind;
		if (extra_q) begin
			op_push = 1'b1;
			op_kind = extra_kind_q;
		end else if (byte_go) begin
			case (hold_q)
				bbc_pkg::HOLD_PAREN: begin
					if (s_axis_tdata == bbc_pkg::CH_STAR) begin
						op_push = 1'b1;
						op_kind = bbc_pkg::KIND_STAR;
					end else if (full) begin
						op_push = 1'b1;
					end else if (s_axis_tdata == bbc_pkg::CH_LPAREN) begin
						op_push  = 1'b1;
						nxt_hold = bbc_pkg::HOLD_PAREN;
					end else if (is_open) begin
						op_push   = 1'b1;
						set_extra = 1'b1;
					end else if (is_close) begin
						// The held parenthesis is pushed and popped at once.
						force_fail = (close_kind != bbc_pkg::KIND_PAREN);
					end else begin
						op_push = 1'b1;
					end
				end
				bbc_pkg::HOLD_STAR: begin
					if (s_axis_tdata == bbc_pkg::CH_RPAREN) begin
						op_pop  = 1'b1;
						op_kind = bbc_pkg::KIND_STAR;
					end else begin
						op_push  = p_push;
						op_pop   = p_pop;
						op_kind  = p_kind;
						nxt_hold = p_hold;
					end
				end
				default: begin
					op_push  = p_push;
					op_pop   = p_pop;
					op_kind  = p_kind;
					nxt_hold = p_hold;
				end
			endcase
		end
	end

	assign push_ovf = op_push && full;
	assign push_ok  = op_push && !full;
	assign pop_ok   = op_pop && (level_q != '0) && (top_q == op_kind);
	assign do_fail  = force_fail || push_ovf || (op_pop && !pop_ok);

	always_comb begin
		if (eol_acc) begin
			next_level = '0;
		end else if (push_ok) begin
			next_level = level_q + LVL_W'(1);
		end else if (pop_ok) begin
			next_level = level_q - LVL_W'(1);
		end else begin
			next_level = level_q;
		end
	end

	assign rd_addr  = ADDR_W'(next_level - LVL_W'(2));
	assign wr_en    = push_ok && (level_q != '0);
	assign wr_addr  = ADDR_W'(level_q - LVL_W'(1));

	bbc_ram #(
		.WIDTH(KIND_W),
		.DEPTH(bbc_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (top_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign final_push = (hold_q == bbc_pkg::HOLD_PAREN) && !failed_q;
	assign res_bal    = !failed_q && (level_q == '0) && !final_push;
	assign res_ovf    = overflow_q || (final_push && full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			hold_q       <= bbc_pkg::HOLD_NONE;
			failed_q     <= 1'b0;
			overflow_q   <= 1'b0;
			extra_q      <= 1'b0;
			fwd_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			level_q <= next_level;
			fwd_q   <= wr_en && (wr_addr == rd_addr);
			if (eol_acc) begin
				hold_q     <= bbc_pkg::HOLD_NONE;
				failed_q   <= 1'b0;
				overflow_q <= 1'b0;
			end else begin
				if (do_fail) begin
					hold_q   <= bbc_pkg::HOLD_NONE;
					failed_q <= 1'b1;
				end else if (byte_go) begin
					hold_q <= nxt_hold;
				end
				if (push_ovf) begin
					overflow_q <= 1'b1;
				end
			end
			extra_q <= set_extra && !do_fail;
			if (eol_acc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= top_q;
		if (push_ok) begin
			top_q <= op_kind;
		end else if (pop_ok) begin
			top_q <= below;
		end
		if (set_extra) begin
			extra_kind_q <= set_extra_kind;
		end
		if (eol_acc) begin
			out_bal_q <= res_bal;
			out_ovf_q <= res_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_ovf_q, out_bal_q};

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= bbc_pkg::LEVEL_FULL)
		else $error("stack level beyond depth");

	a_extra_clean: assert property (@(posedge clk) disable iff (!arst_n)
		extra_q |-> (!failed_q && hold_q == bbc_pkg::HOLD_NONE))
		else $error("second push pending in a bad state");

	a_fail_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> (hold_q == bbc_pkg::HOLD_NONE))
		else $error("byte held after a failure");

	a_ovf_fails: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> failed_q)
		else $error("overflow without failure");

endmodule

`default_nettype wire

FILE: rtl/core/bbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: verif/bracket_balance_checker_tb.sv
// Self-checking testbench for the bracket balance checker: line stimulus, prediction and checks.
`default_nettype none

module bracket_balance_checker_tb;

	localparam int STACK_DEPTH    = bbc_pkg::STACK_DEPTH;
	localparam int KIND_W         = bbc_pkg::KIND_W;
	localparam int LVL_W          = bbc_pkg::LVL_W;
	localparam int ADDR_W         = bbc_pkg::ADDR_W;
	localparam int WORD_TARGET    = 1750;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic overflowed;
		logic balanced;
	} verdict_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;   // text_byte
	logic       s_axis_tlast  = 1'b0;    // line_end
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;            // balanced, overflowed, zero fill

	bracket_balance_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	logic [KIND_W-1:0] nest_kinds [STACK_DEPTH];
	logic [LVL_W-1:0]  nest_depth    = '0;
	logic [1:0]        held_byte     = bbc_pkg::HOLD_NONE;
	logic              line_failed   = 1'b0;
	logic              line_overflow = 1'b0;

	verdict_t   expected_verdicts [$];
	verdict_t   want;
	logic [7:0] line_buf [$];
	int         words_sent    = 0;
	int         burst_left    = 0;
	int         mismatches    = 0;
	int         lines_checked = 0;
	int         idle_cycles   = 0;
	int         ready_mode    = 0;
	int         ready_span    = 0;

	function automatic void push_nest(input logic [KIND_W-1:0] kind);
		if (!line_failed) begin
			if (nest_depth >= bbc_pkg::LEVEL_FULL) begin
				line_overflow = 1'b1;
				line_failed   = 1'b1;
			end else begin
				nest_kinds[nest_depth[ADDR_W-1:0]] = kind;
				nest_depth = nest_depth + 1'b1;
			end
		end
	endfunction

	function automatic void pop_nest(input logic [KIND_W-1:0] kind);
		logic [LVL_W-1:0] top_idx;
		top_idx = nest_depth - 1'b1;
		if (!line_failed) begin
			if (nest_depth == 0 || nest_kinds[top_idx[ADDR_W-1:0]] != kind)
				line_failed = 1'b1;
			else
				nest_depth = nest_depth - 1'b1;
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		case (b)
			bbc_pkg::CH_LPAREN: held_byte = bbc_pkg::HOLD_PAREN;
			bbc_pkg::CH_STAR:   held_byte = bbc_pkg::HOLD_STAR;
			bbc_pkg::CH_LBRACK: push_nest(bbc_pkg::KIND_BRACK);
			bbc_pkg::CH_LBRACE: push_nest(bbc_pkg::KIND_BRACE);
			bbc_pkg::CH_LT:     push_nest(bbc_pkg::KIND_ANGLE);
			bbc_pkg::CH_RPAREN: pop_nest(bbc_pkg::KIND_PAREN);
			bbc_pkg::CH_RBRACK: pop_nest(bbc_pkg::KIND_BRACK);
			bbc_pkg::CH_RBRACE: pop_nest(bbc_pkg::KIND_BRACE);
			bbc_pkg::CH_GT:     pop_nest(bbc_pkg::KIND_ANGLE);
			default:            ;
		endcase
	endfunction

	function automatic void feed_byte(input logic [7:0] b);
		logic [1:0] was_held;
		was_held  = held_byte;
		held_byte = bbc_pkg::HOLD_NONE;
		if (!line_failed) begin
			if (was_held == bbc_pkg::HOLD_PAREN && b == bbc_pkg::CH_STAR) begin
				push_nest(bbc_pkg::KIND_STAR);
			end else if (was_held == bbc_pkg::HOLD_STAR && b == bbc_pkg::CH_RPAREN) begin
				pop_nest(bbc_pkg::KIND_STAR);
			end else begin
				if (was_held == bbc_pkg::HOLD_PAREN)
					push_nest(bbc_pkg::KIND_PAREN);
				if (!line_failed)
					scan_byte(b);
			end
		end
	endfunction

	function automatic verdict_t close_line();
		verdict_t v;
		if (held_byte == bbc_pkg::HOLD_PAREN && !line_failed)
			push_nest(bbc_pkg::KIND_PAREN);
		v.balanced    = !line_failed && nest_depth == 0;
		v.overflowed  = line_overflow;
		held_byte     = bbc_pkg::HOLD_NONE;
		nest_depth    = '0;
		line_failed   = 1'b0;
		line_overflow = 1'b0;
		return v;
	endfunction

	function automatic logic [7:0] pick_token(input int idx);
		case (idx)
			0:       return bbc_pkg::CH_LPAREN;
			1:       return bbc_pkg::CH_RPAREN;
			2:       return bbc_pkg::CH_STAR;
			3:       return bbc_pkg::CH_LT;
			4:       return bbc_pkg::CH_GT;
			5:       return bbc_pkg::CH_LBRACK;
			6:       return bbc_pkg::CH_RBRACK;
			7:       return bbc_pkg::CH_LBRACE;
			default: return bbc_pkg::CH_RBRACE;
		endcase
	endfunction

	function automatic logic is_token_byte(input logic [7:0] b);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 9; i++)
			if (pick_token(i) == b)
				hit = 1'b1;
		return hit;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (got_val !== exp_val) begin
			if (mismatches < 10)
				$display("line %0d %s: expected %0h, got %0h", lines_checked, name, exp_val,
					got_val);
			mismatches++;
		end
	endtask

	// Prediction is done before the result check in the same clocked block, so that their order is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tlast)
					expected_verdicts.push_back(close_line());
				else
					feed_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_verdicts.size() == 0) begin
					if (mismatches < 10)
						$display("result word %0h with no line pending", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("balanced", {7'd0, want.balanced}, {7'd0, m_axis_tdata[0]});
					check_field("overflowed", {7'd0, want.overflowed}, {7'd0, m_axis_tdata[1]});
					check_field("fill", 8'd0, {2'd0, m_axis_tdata[7:2]});
				end
				lines_checked++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (ready_span == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_span = $urandom_range(8, 48);
		end else begin
			ready_span--;
		end
		case (ready_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= 1'($urandom_range(0, 1));
			2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (ready_span < 4);
		endcase
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		if (burst_left == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 7)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
		end
		@(negedge clk);
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic flush_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_word(line_buf[i], 1'b0);
		send_word(8'($urandom_range(0, 255)), 1'b1);
		line_buf.delete();
	endtask

	task automatic add_closer(input logic [KIND_W-1:0] kind);
		case (kind)
			bbc_pkg::KIND_PAREN: line_buf.push_back(bbc_pkg::CH_RPAREN);
			bbc_pkg::KIND_BRACK: line_buf.push_back(bbc_pkg::CH_RBRACK);
			bbc_pkg::KIND_BRACE: line_buf.push_back(bbc_pkg::CH_RBRACE);
			bbc_pkg::KIND_ANGLE: line_buf.push_back(bbc_pkg::CH_GT);
			default: begin
				line_buf.push_back(bbc_pkg::CH_STAR);
				line_buf.push_back(bbc_pkg::CH_RPAREN);
			end
		endcase
	endtask

	task automatic build_nested_line();
		int                cap;
		int                steps;
		int                bias;
		int                r;
		logic [KIND_W-1:0] kind;
		logic [7:0]        b;
		logic [KIND_W-1:0] open_kinds [$];
		if ($urandom_range(0, 24) == 0) begin
			cap   = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 1);
			bias  = 10;
			steps = cap + 20;
		end else begin
			cap   = $urandom_range(1, 8);
			bias  = 6;
			steps = $urandom_range(0, 3 * cap + 4);
		end
		for (int i = 0; i < steps; i++) begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				do
					b = 8'($urandom_range(0, 255));
				while (is_token_byte(b));
				line_buf.push_back(b);
			end else if (open_kinds.size() < cap && (open_kinds.size() == 0 || r < bias)) begin
				kind = 3'($urandom_range(bbc_pkg::KIND_PAREN, bbc_pkg::KIND_STAR));
				open_kinds.push_back(kind);
				case (kind)
					bbc_pkg::KIND_PAREN: line_buf.push_back(bbc_pkg::CH_LPAREN);
					bbc_pkg::KIND_BRACK: line_buf.push_back(bbc_pkg::CH_LBRACK);
					bbc_pkg::KIND_BRACE: line_buf.push_back(bbc_pkg::CH_LBRACE);
					bbc_pkg::KIND_ANGLE: line_buf.push_back(bbc_pkg::CH_LT);
					default: begin
						line_buf.push_back(bbc_pkg::CH_LPAREN);
						line_buf.push_back(bbc_pkg::CH_STAR);
					end
				endcase
			end else if (open_kinds.size() > 0) begin
				add_closer(open_kinds.pop_back());
			end
		end
		if ($urandom_range(0, 7) != 0)
			while (open_kinds.size() > 0)
				add_closer(open_kinds.pop_back());
	endtask

	task automatic build_token_soup();
		int len;
		len = $urandom_range(1, 30);
		repeat (len) begin
			if ($urandom_range(0, 1) == 1)
				line_buf.push_back(pick_token($urandom_range(0, 8)));
			else
				line_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed_lines();
		flush_line();
		add_text("(*x*)");
		flush_line();
		add_text("(]");
		flush_line();
		add_text(">(");
		flush_line();
		add_text("([])");
		flush_line();
		add_text("*(");
		flush_line();
		line_buf.push_back(8'h00);
		add_text("<{}>");
		line_buf.push_back(8'hFF);
		add_text("*");
		flush_line();
		add_text("(*)");
		flush_line();
	endtask

	task automatic test_deep_nesting();
		repeat (STACK_DEPTH) line_buf.push_back(bbc_pkg::CH_LT);
		repeat (STACK_DEPTH) line_buf.push_back(bbc_pkg::CH_GT);
		flush_line();
		repeat (STACK_DEPTH + 1) line_buf.push_back(bbc_pkg::CH_LBRACE);
		line_buf.push_back(bbc_pkg::CH_RBRACE);
		flush_line();
		repeat (STACK_DEPTH) line_buf.push_back(bbc_pkg::CH_LBRACK);
		line_buf.push_back(bbc_pkg::CH_LPAREN);
		flush_line();
		repeat (STACK_DEPTH - 1) line_buf.push_back(bbc_pkg::CH_LBRACK);
		line_buf.push_back(bbc_pkg::CH_LPAREN);
		line_buf.push_back(bbc_pkg::CH_LBRACE);
		flush_line();
	endtask

	task automatic test_random_lines();
		while (words_sent < WORD_TARGET) begin
			if ($urandom_range(0, 19) < 15)
				build_nested_line();
			else
				build_token_soup();
			flush_line();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_lines();
		test_deep_nesting();
		test_random_lines();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/bbc_pkg.sv
rtl/core/bbc_ram.sv
rtl/core/bracket_balance_checker.sv
verif/bracket_balance_checker_tb.sv
